// ===== rtl/xoshiro256ss_prng_splitmix_seed_assert.svh =====
// Assertion macros for the files that check their own logic.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef XOSHIRO256SS_PRNG_SPLITMIX_SEED_ASSERT_SVH
`define XOSHIRO256SS_PRNG_SPLITMIX_SEED_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XSR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/xsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package xsr_pkg;
	localparam int WORD_W = 64;
	localparam int HALF_W = 32;
	localparam int FRAC_W = 53;

	localparam logic CMD_NEXT = 1'b0;
	localparam logic CMD_SEED = 1'b1;

	localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
	localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;

	// Partial product selected in each cycle of a 64-bit modular multiply.
	localparam logic [1:0] PP_LL = 2'd0;
	localparam logic [1:0] PP_LH = 2'd1;
	localparam logic [1:0] PP_HL = 2'd2;

	typedef struct packed {
		logic       busy;
		logic       load_seed;
		logic       step;
		logic       load_out;
		logic       prep;
		logic       mul_en;
		logic [1:0] mul_k;
		logic       mul_b;
		logic       mid;
		logic       store;
		logic [1:0] word_idx;
	} xsr_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/xsr_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface xsr_req_if import xsr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [WORD_W-1:0] seed_value;

	modport source (output valid, output command, output seed_value, input ready);
	modport sink (input valid, input command, input seed_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/xsr_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface xsr_rsp_if import xsr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] random_word;
	logic [FRAC_W-1:0] uniform_fraction;

	modport source (output valid, output random_word, output uniform_fraction, input ready);
	modport sink (input valid, input random_word, input uniform_fraction, output ready);
endinterface
`default_nettype wire

// ===== rtl/xoshiro256ss_prng_splitmix_seed.sv =====
// Channel   Modport  Transaction
// request   sink     command (0 next, 1 reseed) and 64-bit seed value
// result    source   random word and 53-bit uniform fraction, one per next command
//
// A next command is taken every cycle while no reseed runs and the result path is not stalled;
// the scrambler stage loads at the accepting edge, then the output register loads the result.
// A reseed holds request.ready low through four splitmix64 rounds, each in prep, multiply,
// mid, multiply and store, the shared 32x32 multiplier summing three partial products each.
// Reset clears the generator state to zero and empties the result path.
// A stalled result channel stops the input once the scrambler stage is also full.
`timescale 1ns / 1ps
`default_nettype none
`include "xoshiro256ss_prng_splitmix_seed_assert.svh"
module xoshiro256ss_prng_splitmix_seed import xsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	xsr_req_if.sink   request,
	xsr_rsp_if.source result
);
	xsr_cmd_t cmd;

	xsr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (request.valid),
		.in_command (request.command),
		.out_ready  (result.ready),
		.in_ready   (request.ready),
		.out_valid  (result.valid),
		.cmd        (cmd)
	);

	xsr_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.seed_value       (request.seed_value),
		.random_word      (result.random_word),
		.uniform_fraction (result.uniform_fraction)
	);

	`XSR_ASSERT_SAME(a_busy_blocks_input, cmd.busy, !request.ready, "input taken while reseeding")
	`XSR_ASSERT_NEXT(a_seed_starts_busy, request.valid && request.ready && request.command == CMD_SEED, cmd.busy, "reseed did not start")
	`XSR_ASSERT_SAME(a_fraction_matches, result.valid, result.uniform_fraction == result.random_word[WORD_W-1:WORD_W-FRAC_W], "fraction differs from word")
endmodule
`default_nettype wire

// ===== rtl/xsr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xsr_ctrl import xsr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_command,
	input  logic     out_ready,
	output logic     in_ready,
	output logic     out_valid,
	output xsr_cmd_t cmd
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_MID   = 3'd3;
	localparam logic [2:0] ST_STORE = 3'd4;

	logic [2:0] state_q, state_d;
	logic [1:0] word_q, word_d;
	logic [1:0] pp_q, pp_d;
	logic       mulb_q, mulb_d;
	logic       s1v_q;
	logic       outv_q;
	logic       adv;
	logic       take;

	assign adv       = !outv_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && (!s1v_q || adv);
	assign take      = in_valid && in_ready;
	assign out_valid = outv_q;

	always_comb begin
		state_d       = state_q;
		word_d        = word_q;
		pp_d          = pp_q;
		mulb_d        = mulb_q;
		cmd           = '0;
		cmd.busy      = (state_q != ST_IDLE);
		cmd.load_out  = s1v_q && adv;
		cmd.mul_k     = pp_q;
		cmd.mul_b     = mulb_q;
		cmd.word_idx  = word_q;
		case (state_q)
			ST_IDLE: begin
				if (take && (in_command == CMD_SEED)) begin
					cmd.load_seed = 1'b1;
					word_d        = 2'd0;
					state_d       = ST_PREP;
				end else if (take) begin
					cmd.step = 1'b1;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				pp_d     = PP_LL;
				mulb_d   = 1'b0;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (pp_q == PP_HL) begin
					pp_d    = PP_LL;
					state_d = mulb_q ? ST_STORE : ST_MID;
				end else begin
					pp_d = pp_q + 2'd1;
				end
			end
			ST_MID: begin
				cmd.mid = 1'b1;
				mulb_d  = 1'b1;
				state_d = ST_MUL;
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (word_q == 2'd3) begin
					state_d = ST_IDLE;
				end else begin
					word_d  = word_q + 2'd1;
					state_d = ST_PREP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			word_q  <= 2'd0;
			pp_q    <= PP_LL;
			mulb_q  <= 1'b0;
			s1v_q   <= 1'b0;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			word_q  <= word_d;
			pp_q    <= pp_d;
			mulb_q  <= mulb_d;
			if (cmd.step) begin
				s1v_q <= 1'b1;
			end else if (cmd.load_out) begin
				s1v_q <= 1'b0;
			end
			if (cmd.load_out) begin
				outv_q <= 1'b1;
			end else if (out_ready) begin
				outv_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/xsr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xsr_datapath import xsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  xsr_cmd_t          cmd,
	input  logic [WORD_W-1:0] seed_value,
	output logic [WORD_W-1:0] random_word,
	output logic [FRAC_W-1:0] uniform_fraction
);
	logic [WORD_W-1:0] s_q [4];
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] m5_s1;
	logic [WORD_W-1:0] word_q;

	logic [WORD_W-1:0] acc_next;
	logic [WORD_W-1:0] n0, n1, n2, n3;
	logic [WORD_W-1:0] rot_w;
	logic [WORD_W-1:0] konst;
	logic [HALF_W-1:0] mul_a, mul_b;
	logic [WORD_W-1:0] mul_p;

	assign acc_next = acc_q + GOLDEN_GAMMA;

	assign n2 = s_q[2] ^ s_q[0];
	assign n3 = s_q[3] ^ s_q[1];
	assign n1 = s_q[1] ^ n2;
	assign n0 = s_q[0] ^ n3;

	assign rot_w = {m5_s1[WORD_W-8:0], m5_s1[WORD_W-1:WORD_W-7]};

	assign konst = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;
	assign mul_a = (cmd.mul_k == PP_HL) ? x_q[WORD_W-1:HALF_W] : x_q[HALF_W-1:0];
	assign mul_b = (cmd.mul_k == PP_LH) ? konst[WORD_W-1:HALF_W] : konst[HALF_W-1:0];
	assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

	assign random_word      = word_q;
	assign uniform_fraction = word_q[WORD_W-1:WORD_W-FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				s_q[i] <= '0;
			end
		end else if (cmd.step) begin
			s_q[0] <= n0;
			s_q[1] <= n1;
			s_q[2] <= n2 ^ (s_q[1] << 17);
			s_q[3] <= {n3[WORD_W-46:0], n3[WORD_W-1:WORD_W-45]};
		end else if (cmd.store) begin
			s_q[cmd.word_idx] <= prod_q ^ (prod_q >> 31);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			acc_q <= seed_value;
		end else if (cmd.prep) begin
			acc_q <= acc_next;
		end
		if (cmd.prep) begin
			x_q <= acc_next ^ (acc_next >> 30);
		end else if (cmd.mid) begin
			x_q <= prod_q ^ (prod_q >> 27);
		end
		if (cmd.mul_en) begin
			if (cmd.mul_k == PP_LL) begin
				prod_q <= mul_p;
			end else begin
				prod_q[WORD_W-1:HALF_W] <= prod_q[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
			end
		end
		if (cmd.step) begin
			m5_s1 <= s_q[1] + (s_q[1] << 2);
		end
		if (cmd.load_out) begin
			word_q <= rot_w + (rot_w << 3);
		end
	end
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import xsr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1430;
	localparam int CALM_TAIL = 200;
	localparam int LONG_HOLD_CYCLES = 80;

	typedef struct {
		logic              command;
		logic [WORD_W-1:0] seed;
		bit                drain_first;
	} gen_cmd_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [FRAC_W-1:0] frac;
	} gen_out_t;

	logic clk = 1'b0;
	logic arst_n;

	xsr_req_if req_ch ();
	xsr_rsp_if rsp_ch ();

	xoshiro256ss_prng_splitmix_seed u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (rsp_ch)
	);

	always #1 clk = ~clk;

	gen_cmd_t          cmd_backlog[$];
	gen_out_t          pending_words[$];
	logic [WORD_W-1:0] gen_state[4];
	int                total_cmds;
	int                accepted_count;
	int                fail_count;
	int                cycle_count;
	bit                req_taken;

	function automatic logic [WORD_W-1:0] rotl64(logic [WORD_W-1:0] v, int unsigned n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	// Four splitmix64 rounds overwrite the whole generator state.
	function automatic void splitmix_fill(logic [WORD_W-1:0] seed);
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] z;
		acc = seed;
		for (int i = 0; i < 4; i++) begin
			acc = acc + GOLDEN_GAMMA;
			z = acc;
			z = (z ^ (z >> 30)) * MIX_MUL_A;
			z = (z ^ (z >> 27)) * MIX_MUL_B;
			gen_state[i] = z ^ (z >> 31);
		end
	endfunction

	function automatic gen_out_t xoshiro_next();
		gen_out_t          res;
		logic [WORD_W-1:0] shifted;
		res.word = rotl64(gen_state[1] * 64'd5, 7) * 64'd9;
		res.frac = res.word[WORD_W-1:WORD_W-FRAC_W];
		shifted = gen_state[1] << 17;
		gen_state[2] = gen_state[2] ^ gen_state[0];
		gen_state[3] = gen_state[3] ^ gen_state[1];
		gen_state[1] = gen_state[1] ^ gen_state[2];
		gen_state[0] = gen_state[0] ^ gen_state[3];
		gen_state[2] = gen_state[2] ^ shifted;
		gen_state[3] = rotl64(gen_state[3], 45);
		return res;
	endfunction

	function automatic logic [WORD_W-1:0] random_seed();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic add_cmd(logic command, logic [WORD_W-1:0] seed, bit drain_first);
		gen_cmd_t c;
		c.command = command;
		c.seed = seed;
		c.drain_first = drain_first;
		cmd_backlog.push_back(c);
		total_cmds++;
	endtask

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Results are checked before the accepted request updates the prediction.
	always @(posedge clk) begin : observe
		gen_out_t want;
		req_taken = arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result transaction word %h frac %h", $time,
					rsp_ch.random_word, rsp_ch.uniform_fraction);
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				if (rsp_ch.random_word !== want.word) begin
					$display("%0t: random_word expected %h actual %h", $time,
						want.word, rsp_ch.random_word);
					fail_count++;
				end
				if (rsp_ch.uniform_fraction !== want.frac) begin
					$display("%0t: uniform_fraction expected %h actual %h", $time,
						want.frac, rsp_ch.uniform_fraction);
					fail_count++;
				end
			end
		end
		if (req_taken) begin
			accepted_count++;
			if (req_ch.command == CMD_SEED)
				splitmix_fill(req_ch.seed_value);
			else
				pending_words.push_back(xoshiro_next());
		end
	end

	always @(negedge clk) begin : drive_request
		bit       offer;
		gen_cmd_t item;
		int       send_gap;
		offer = req_ch.valid && !req_taken;
		if (arst_n && !offer) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (cmd_backlog.size() > 0 &&
					!(cmd_backlog[0].drain_first && pending_words.size() > 0)) begin
				if (cmd_backlog.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(1, 14) - 1;
				end else begin
					item = cmd_backlog.pop_front();
					req_ch.command <= item.command;
					req_ch.seed_value <= item.seed;
					offer = 1'b1;
				end
			end
		end
		req_ch.valid <= offer;
	end

	always @(negedge clk) begin : drive_result_ready
		bit take;
		int stall_left;
		int long_hold;
		int next_hold_at;
		if (next_hold_at == 0)
			next_hold_at = 300;
		if (long_hold == 0 && next_hold_at <= 900 && accepted_count >= next_hold_at) begin
			long_hold = LONG_HOLD_CYCLES;
			next_hold_at += 600;
		end
		if (long_hold > 0) begin
			long_hold--;
			take = 1'b0;
		end else if (cmd_backlog.size() <= CALM_TAIL) begin
			take = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			take = 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			take = 1'b0;
		end else begin
			take = 1'b1;
		end
		rsp_ch.ready <= take;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_NEXT;
		req_ch.seed_value = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < 4; i++)
			gen_state[i] = '0;

		// Next commands before any seed must return zero, whatever the seed field holds.
		add_cmd(CMD_NEXT, '1, 1'b0);
		add_cmd(CMD_NEXT, '0, 1'b0);
		add_cmd(CMD_NEXT, {$urandom, $urandom}, 1'b0);
		add_cmd(CMD_SEED, '0, 1'b1);
		add_cmd(CMD_NEXT, '0, 1'b0);
		add_cmd(CMD_NEXT, '1, 1'b0);
		add_cmd(CMD_NEXT, 64'h5555_5555_5555_5555, 1'b0);
		add_cmd(CMD_SEED, '1, 1'b0);
		add_cmd(CMD_NEXT, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		add_cmd(CMD_NEXT, '0, 1'b0);
		// Back-to-back reseeds: only the second one must survive.
		add_cmd(CMD_SEED, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		add_cmd(CMD_SEED, 64'h5555_5555_5555_5555, 1'b0);
		add_cmd(CMD_NEXT, '1, 1'b0);
		add_cmd(CMD_NEXT, '1, 1'b0);
		add_cmd(CMD_SEED, 64'd1, 1'b0);
		add_cmd(CMD_NEXT, '0, 1'b0);
		add_cmd(CMD_SEED, 64'h8000_0000_0000_0000, 1'b0);
		add_cmd(CMD_NEXT, '0, 1'b0);
		add_cmd(CMD_NEXT, '0, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 24) == 0)
				add_cmd(CMD_SEED, random_seed(), (i % 150) == 75);
			else
				add_cmd(CMD_NEXT, {$urandom, $urandom}, (i % 150) == 75);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (accepted_count == total_cmds);
		wait (pending_words.size() == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/xsr_pkg.sv
rtl/xsr_req_if.sv
rtl/xsr_rsp_if.sv
rtl/xsr_ctrl.sv
rtl/xsr_datapath.sv
rtl/xoshiro256ss_prng_splitmix_seed.sv
dv/testbench.sv
